// File: design/lhc_pkg.sv
// lhc_pkg: shared types and constants of the LRU hash cache.
// No dependencies; imported by every module of the block.
`default_nettype none
package lhc_pkg;

  localparam int SLOTS      = 2048;
  localparam int SLOT_BITS  = 11;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = 11;
  localparam int TMP_BITS   = 10;

  localparam logic [CNT_BITS-1:0] MIN_LIMIT  = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] MAX_LIMIT  = CNT_BITS'(SLOTS / 2);
  localparam logic [CNT_BITS-1:0] TOMB_LIMIT = CNT_BITS'(SLOTS / 3);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [KEY_BITS-1:0]   key;
    logic [SLOT_BITS-1:0]  hash_index;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] found_value;
    logic                  evicted;
  } rsp_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic init_active;
    logic pop;
  } bk_status_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  home;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } tmp_entry_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_REBUILD
  } sweep_t;

  typedef enum logic [1:0] {
    RET_EVICT,
    RET_PROMOTE,
    RET_NEW
  } ret_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EV_CHK,
    ST_EV_T,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_PLACE,
    ST_LF_RD,
    ST_LF_W1,
    ST_LF_W2,
    ST_RBC_RD,
    ST_RBC_WR,
    ST_RBP_RD,
    ST_RBP_HOME,
    ST_RBP_TRD,
    ST_RBP_TCHK,
    ST_RBP_CLOSE,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// File: design/lhc_front.sv
// lhc_front: request intake and two-entry queue in front of the engine.
// Depends on lhc_pkg.
`default_nettype none
module lhc_front
  import lhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire req_t       req,
  input  wire bk_status_t bk,
  output logic            busy,
  output q_head_t         head
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  // hold off while full or while the tag store is swept after reset
  assign busy = (fill == 2'd2) || bk.init_active;
  assign push = start && !busy;

  assign head.valid = (fill != 2'd0);
  assign head.req   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (bk.pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(bk.pop);
    end
  end

endmodule
`default_nettype wire

// File: design/lhc_back.sv
// lhc_back: execution engine with slot, link and rebuild memories.
// Depends on lhc_pkg; fed by lhc_front.
`default_nettype none
module lhc_back
  import lhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire q_head_t             head,
  input  wire logic [CNT_BITS-1:0] max_entries,
  output bk_status_t               bk,
  output logic                     done,
  output rsp_t                     rsp
);

  // storage
  tag_t                  tag_mem   [SLOTS];
  logic [KEY_BITS-1:0]   key_mem   [SLOTS];
  logic [VALUE_BITS-1:0] val_mem   [SLOTS];
  logic [SLOT_BITS-1:0]  home_mem  [SLOTS];
  logic [SLOT_BITS-1:0]  older_mem [SLOTS];
  logic [SLOT_BITS-1:0]  newer_mem [SLOTS];
  tmp_entry_t            tmp_mem   [SLOTS/2];

  tag_t                  tag_rd;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [SLOT_BITS-1:0]  home_rd;
  logic [SLOT_BITS-1:0]  older_rd;
  logic [SLOT_BITS-1:0]  newer_rd;
  tmp_entry_t            tmp_rd;

  // memory ports
  logic                  tag_we;
  logic [SLOT_BITS-1:0]  tag_wa, tag_ra;
  tag_t                  tag_wd;
  logic [SLOT_BITS-1:0]  dat_ra, dat_wa;
  logic                  key_we, val_we, home_we;
  logic [KEY_BITS-1:0]   key_wd;
  logic [VALUE_BITS-1:0] val_wd;
  logic [SLOT_BITS-1:0]  home_wd;
  logic                  older_we, newer_we;
  logic [SLOT_BITS-1:0]  older_wa, older_wd, older_ra;
  logic [SLOT_BITS-1:0]  newer_wa, newer_wd, newer_ra;
  logic                  tmp_we, tmp_re;
  logic [TMP_BITS-1:0]   tmp_wa, tmp_ra;
  tmp_entry_t            tmp_wd;

  // control state
  state_t                state, state_next;
  sweep_t                sweep_kind, sweep_kind_next;
  logic [SLOT_BITS-1:0]  sweep_idx, sweep_idx_next;
  ret_t                  ret, ret_next;
  logic [1:0]            cur_op, cur_op_next;
  logic [KEY_BITS-1:0]   cur_key, cur_key_next;
  logic [SLOT_BITS-1:0]  cur_home, cur_home_next;
  logic [VALUE_BITS-1:0] cur_val, cur_val_next;
  logic [SLOT_BITS-1:0]  probe_idx, probe_idx_next;
  logic                  have_tomb, have_tomb_next;
  logic [SLOT_BITS-1:0]  tomb_slot, tomb_slot_next;
  logic [SLOT_BITS-1:0]  cur, cur_next;
  logic [SLOT_BITS-1:0]  lf_tail, lf_tail_next;
  logic                  hit_r, hit_r_next;
  logic [VALUE_BITS-1:0] found_r, found_r_next;
  logic                  ev_r, ev_r_next;
  logic [SLOT_BITS-1:0]  front_slot, front_slot_next;
  logic [CNT_BITS-1:0]   entry_count, entry_count_next;
  logic [CNT_BITS-1:0]   tomb_count, tomb_count_next;
  logic [CNT_BITS-1:0]   rb_i, rb_i_next;
  logic [CNT_BITS-1:0]   rb_n, rb_n_next;
  logic [SLOT_BITS-1:0]  rb_s, rb_s_next;
  logic [SLOT_BITS-1:0]  rb_prev, rb_prev_next;

  // decisions
  logic [CNT_BITS-1:0]   lim;
  logic                  need_evict;
  logic                  key_eq;
  logic                  sweep_last;
  logic [CNT_BITS-1:0]   rb_i_inc;

  always_comb begin
    if (max_entries < MIN_LIMIT) begin
      lim = MIN_LIMIT;
    end else if (max_entries > MAX_LIMIT) begin
      lim = MAX_LIMIT;
    end else begin
      lim = max_entries;
    end
  end

  assign need_evict = (entry_count >= lim) && (entry_count != '0);
  assign key_eq     = (key_rd == cur_key);
  assign sweep_last = (sweep_idx == LAST_SLOT);
  assign rb_i_inc   = rb_i + CNT_BITS'(1);

  assign bk.init_active = (state == ST_SWEEP) && (sweep_kind == SW_INIT);
  assign bk.pop         = (state == ST_IDLE) && head.valid;
  assign done            = (state == ST_RESP);
  assign rsp.hit         = hit_r;
  assign rsp.found_value = found_r;
  assign rsp.evicted     = ev_r;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_rd <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[dat_wa] <= key_wd;
    end
    if (val_we) begin
      val_mem[dat_wa] <= val_wd;
    end
    if (home_we) begin
      home_mem[dat_wa] <= home_wd;
    end
    key_rd  <= key_mem[dat_ra];
    val_rd  <= val_mem[dat_ra];
    home_rd <= home_mem[dat_ra];
  end

  always_ff @(posedge clk) begin
    if (older_we) begin
      older_mem[older_wa] <= older_wd;
    end
    older_rd <= older_mem[older_ra];
  end

  always_ff @(posedge clk) begin
    if (newer_we) begin
      newer_mem[newer_wa] <= newer_wd;
    end
    newer_rd <= newer_mem[newer_ra];
  end

  always_ff @(posedge clk) begin
    if (tmp_we) begin
      tmp_mem[tmp_wa] <= tmp_wd;
    end
    if (tmp_re) begin
      tmp_rd <= tmp_mem[tmp_ra];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (sweep_last) begin
          unique case (sweep_kind)
            SW_INIT:    state_next = ST_IDLE;
            SW_CLEAR:   state_next = ST_RESP;
            SW_REBUILD: state_next = (rb_n == '0) ? ST_RBP_CLOSE : ST_RBP_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.req.opcode)
            OP_FIND:   state_next = ST_PRB_RD;
            OP_INSERT: state_next = ST_EV_CHK;
            OP_CLEAR:  state_next = ST_SWEEP;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_EV_CHK:  state_next = need_evict ? ST_EV_T : ST_PRB_RD;
      ST_EV_T:    state_next = ST_UNL_RD;
      ST_UNL_RD:  state_next = ST_UNL_WR;
      ST_UNL_WR: begin
        if (ret == RET_EVICT) begin
          state_next = (tomb_count > TOMB_LIMIT) ? ST_RBC_RD : ST_EV_CHK;
        end else begin
          state_next = ST_LF_RD;
        end
      end
      ST_PRB_RD:  state_next = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if (tag_rd == TAG_EMPTY) begin
          state_next = (cur_op == OP_INSERT) ? ST_PLACE : ST_RESP;
        end else if (tag_rd == TAG_LIVE && key_eq) begin
          state_next = (probe_idx == front_slot) ? ST_RESP : ST_UNL_RD;
        end else begin
          state_next = ST_PRB_RD;
        end
      end
      ST_PLACE:   state_next = (entry_count == '0) ? ST_RESP : ST_LF_RD;
      ST_LF_RD:   state_next = ST_LF_W1;
      ST_LF_W1:   state_next = ST_LF_W2;
      ST_LF_W2:   state_next = ST_RESP;
      ST_RBC_RD:  state_next = (rb_i == rb_n) ? ST_SWEEP : ST_RBC_WR;
      ST_RBC_WR:  state_next = ST_RBC_RD;
      ST_RBP_RD:  state_next = ST_RBP_HOME;
      ST_RBP_HOME: state_next = ST_RBP_TRD;
      ST_RBP_TRD: state_next = ST_RBP_TCHK;
      ST_RBP_TCHK: begin
        if (tag_rd == TAG_EMPTY) begin
          state_next = (rb_i_inc == rb_n) ? ST_RBP_CLOSE : ST_RBP_RD;
        end else begin
          state_next = ST_RBP_TRD;
        end
      end
      ST_RBP_CLOSE: state_next = ST_EV_CHK;
      ST_RESP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    sweep_kind_next  = sweep_kind;
    sweep_idx_next   = sweep_idx;
    ret_next         = ret;
    cur_op_next      = cur_op;
    cur_key_next     = cur_key;
    cur_home_next    = cur_home;
    cur_val_next     = cur_val;
    probe_idx_next   = probe_idx;
    have_tomb_next   = have_tomb;
    tomb_slot_next   = tomb_slot;
    cur_next         = cur;
    lf_tail_next     = lf_tail;
    hit_r_next       = hit_r;
    found_r_next     = found_r;
    ev_r_next        = ev_r;
    front_slot_next  = front_slot;
    entry_count_next = entry_count;
    tomb_count_next  = tomb_count;
    rb_i_next        = rb_i;
    rb_n_next        = rb_n;
    rb_s_next        = rb_s;
    rb_prev_next     = rb_prev;

    tag_we   = 1'b0;
    tag_wa   = probe_idx;
    tag_wd   = TAG_EMPTY;
    tag_ra   = probe_idx;
    dat_ra   = probe_idx;
    dat_wa   = probe_idx;
    key_we   = 1'b0;
    val_we   = 1'b0;
    home_we  = 1'b0;
    key_wd   = cur_key;
    val_wd   = cur_val;
    home_wd  = cur_home;
    older_we = 1'b0;
    older_wa = cur;
    older_wd = cur;
    older_ra = cur;
    newer_we = 1'b0;
    newer_wa = cur;
    newer_wd = cur;
    newer_ra = cur;
    tmp_we   = 1'b0;
    tmp_wa   = rb_i[TMP_BITS-1:0];
    tmp_wd   = '{home: home_rd, key: key_rd, value: val_rd};
    tmp_re   = 1'b0;
    tmp_ra   = rb_i[TMP_BITS-1:0];

    unique case (state)
      ST_SWEEP: begin
        tag_we         = 1'b1;
        tag_wa         = sweep_idx;
        sweep_idx_next = sweep_idx + SLOT_BITS'(1);
        rb_i_next      = '0;
      end
      ST_IDLE: begin
        if (head.valid) begin
          cur_op_next    = head.req.opcode;
          cur_key_next   = head.req.key;
          cur_home_next  = head.req.hash_index;
          cur_val_next   = head.req.value;
          probe_idx_next = head.req.hash_index;
          have_tomb_next = 1'b0;
          hit_r_next     = 1'b0;
          found_r_next   = '0;
          ev_r_next      = 1'b0;
          if (head.req.opcode == OP_CLEAR) begin
            front_slot_next  = '0;
            entry_count_next = '0;
            tomb_count_next  = '0;
            sweep_idx_next   = '0;
            sweep_kind_next  = SW_CLEAR;
          end
        end
      end
      ST_EV_CHK: begin
        newer_ra       = front_slot;
        probe_idx_next = cur_home;
        have_tomb_next = 1'b0;
      end
      ST_EV_T: begin
        // tail is the slot newer than the front on the circular list
        cur_next         = newer_rd;
        tag_we           = 1'b1;
        tag_wa           = newer_rd;
        tag_wd           = TAG_TOMB;
        entry_count_next = entry_count - CNT_BITS'(1);
        tomb_count_next  = tomb_count + CNT_BITS'(1);
        ev_r_next        = 1'b1;
        ret_next         = RET_EVICT;
      end
      ST_UNL_RD: begin
        newer_ra = cur;
        older_ra = cur;
      end
      ST_UNL_WR: begin
        older_we  = 1'b1;
        older_wa  = newer_rd;
        older_wd  = older_rd;
        newer_we  = 1'b1;
        newer_wa  = older_rd;
        newer_wd  = newer_rd;
        rb_n_next = entry_count;
        rb_i_next = '0;
        rb_s_next = front_slot;
      end
      ST_PRB_RD: begin
        tag_ra = probe_idx;
        dat_ra = probe_idx;
      end
      ST_PRB_CHK: begin
        if (tag_rd == TAG_EMPTY) begin
          cur_next = have_tomb ? tomb_slot : probe_idx;
        end else if (tag_rd == TAG_LIVE && key_eq) begin
          hit_r_next = 1'b1;
          cur_next   = probe_idx;
          ret_next   = RET_PROMOTE;
          if (cur_op == OP_INSERT) begin
            val_we = 1'b1;
          end else begin
            found_r_next = val_rd;
          end
        end else begin
          if (tag_rd == TAG_TOMB && !have_tomb) begin
            have_tomb_next = 1'b1;
            tomb_slot_next = probe_idx;
          end
          probe_idx_next = probe_idx + SLOT_BITS'(1);
        end
      end
      ST_PLACE: begin
        tag_we  = 1'b1;
        tag_wa  = cur;
        tag_wd  = TAG_LIVE;
        dat_wa  = cur;
        key_we  = 1'b1;
        val_we  = 1'b1;
        home_we = 1'b1;
        ret_next = RET_NEW;
        if (have_tomb) begin
          tomb_count_next = tomb_count - CNT_BITS'(1);
        end
        if (entry_count == '0) begin
          older_we         = 1'b1;
          newer_we         = 1'b1;
          front_slot_next  = cur;
          entry_count_next = CNT_BITS'(1);
        end
      end
      ST_LF_RD: begin
        newer_ra = front_slot;
      end
      ST_LF_W1: begin
        lf_tail_next = newer_rd;
        newer_we     = 1'b1;
        newer_wd     = newer_rd;
        older_we     = 1'b1;
        older_wd     = front_slot;
      end
      ST_LF_W2: begin
        older_we        = 1'b1;
        older_wa        = lf_tail;
        older_wd        = cur;
        newer_we        = 1'b1;
        newer_wa        = front_slot;
        newer_wd        = cur;
        front_slot_next = cur;
        if (ret == RET_NEW) begin
          entry_count_next = entry_count + CNT_BITS'(1);
        end
      end
      ST_RBC_RD: begin
        dat_ra   = rb_s;
        older_ra = rb_s;
        if (rb_i == rb_n) begin
          tomb_count_next = '0;
          sweep_idx_next  = '0;
          sweep_kind_next = SW_REBUILD;
        end
      end
      ST_RBC_WR: begin
        tmp_we    = 1'b1;
        rb_s_next = older_rd;
        rb_i_next = rb_i_inc;
      end
      ST_RBP_RD: begin
        tmp_re = 1'b1;
      end
      ST_RBP_HOME: begin
        probe_idx_next = tmp_rd.home;
      end
      ST_RBP_TRD: begin
        tag_ra = probe_idx;
      end
      ST_RBP_TCHK: begin
        if (tag_rd == TAG_EMPTY) begin
          tag_we  = 1'b1;
          tag_wd  = TAG_LIVE;
          key_we  = 1'b1;
          val_we  = 1'b1;
          home_we = 1'b1;
          key_wd  = tmp_rd.key;
          val_wd  = tmp_rd.value;
          home_wd = tmp_rd.home;
          if (rb_i == '0) begin
            front_slot_next = probe_idx;
          end else begin
            older_we = 1'b1;
            older_wa = rb_prev;
            older_wd = probe_idx;
            newer_we = 1'b1;
            newer_wa = probe_idx;
            newer_wd = rb_prev;
          end
          rb_prev_next = probe_idx;
          rb_i_next    = rb_i_inc;
        end else begin
          probe_idx_next = probe_idx + SLOT_BITS'(1);
        end
      end
      ST_RBP_CLOSE: begin
        // close the ring: oldest points back to the front
        if (rb_n != '0) begin
          older_we = 1'b1;
          older_wa = rb_prev;
          older_wd = front_slot;
          newer_we = 1'b1;
          newer_wa = front_slot;
          newer_wd = rb_prev;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_kind  <= SW_INIT;
      sweep_idx   <= '0;
      front_slot  <= '0;
      entry_count <= '0;
      tomb_count  <= '0;
      hit_r       <= 1'b0;
      found_r     <= '0;
      ev_r        <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_kind  <= sweep_kind_next;
      sweep_idx   <= sweep_idx_next;
      front_slot  <= front_slot_next;
      entry_count <= entry_count_next;
      tomb_count  <= tomb_count_next;
      hit_r       <= hit_r_next;
      found_r     <= found_r_next;
      ev_r        <= ev_r_next;
    end
  end

  always_ff @(posedge clk) begin
    ret       <= ret_next;
    cur_op    <= cur_op_next;
    cur_key   <= cur_key_next;
    cur_home  <= cur_home_next;
    cur_val   <= cur_val_next;
    probe_idx <= probe_idx_next;
    have_tomb <= have_tomb_next;
    tomb_slot <= tomb_slot_next;
    cur       <= cur_next;
    lf_tail   <= lf_tail_next;
    rb_i      <= rb_i_next;
    rb_n      <= rb_n_next;
    rb_s      <= rb_s_next;
    rb_prev   <= rb_prev_next;
  end

endmodule
`default_nettype wire

// File: design/lru_hash_cache.sv
// lru_hash_cache: top level of the LRU key/value cache.
// Depends on lhc_pkg, lhc_front and lhc_back.
//
// Channel   Direction  Handshake             Payload
// request   in         start high, busy low  req   (req_t)
// result    out        done strobe, 1 cycle  rsp   (rsp_t)
// config    in         cfg_wr_en             cfg_wr_data (max_entries)
//
// One result per request, in request order. A find reads and checks the slots from
// the home slot on; the unused opcode only returns a result. An insert first checks
// the capacity and evicts until below it, then promotes a hit or links a new entry.
// Clear sweeps the tag store. A rebuild copies each live entry, sweeps the tags, then
// re-places each entry by probing from its home slot. After reset busy stays high
// while the tag store is swept. The result cannot be stalled; a two-deep queue takes
// new requests while the engine works, until it is full.
`default_nettype none
module lru_hash_cache
  import lhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire req_t                req,
  output logic                     busy,
  output logic                     done,
  output rsp_t                     rsp,
  input  wire logic                cfg_wr_en,
  input  wire logic [CNT_BITS-1:0] cfg_wr_data
);

  logic [CNT_BITS-1:0] max_entries;
  q_head_t             head;
  bk_status_t          bk;

  // capacity register; clamped to a legal range where used
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_LIMIT;
    end else if (cfg_wr_en) begin
      max_entries <= cfg_wr_data;
    end
  end

  lhc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .bk    (bk),
    .busy  (busy),
    .head  (head)
  );

  lhc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .max_entries (max_entries),
    .bk          (bk),
    .done        (done),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire

// File: design/lhc_checker.sv
// lhc_checker: port-level checks of lru_hash_cache, bound to the top.
// Depends on lhc_pkg.
`default_nettype none
module lhc_checker
  import lhc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t rsp
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_evict_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.evicted) |-> (rsp.found_value == '0))
    else $error("evicting insert returned a value");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.found_value != '0) |-> rsp.hit)
    else $error("value returned without hit");

endmodule

bind lru_hash_cache lhc_checker u_lhc_checker (
  .clk  (clk),
  .rst  (rst),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
`default_nettype wire

// File: dv/tb_lru_hash_cache.sv
// tb_lru_hash_cache: self-checking testbench of the LRU hash cache.
// Depends on lhc_pkg and lru_hash_cache; holds its own model of the cache.
`timescale 1ns / 100ps
`default_nettype none
module tb_lru_hash_cache;
  import lhc_pkg::*;

  localparam int         WATCH_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  req_t                req = '0;
  logic                busy;
  logic                done;
  rsp_t                rsp;
  logic                cfg_wr_en = 1'b0;
  logic [CNT_BITS-1:0] cfg_wr_data = '0;

  lru_hash_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .done(done), .rsp(rsp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Cache mirror: tags, contents and the circular recency list.
  tag_t                  m_tag   [SLOTS];
  logic [KEY_BITS-1:0]   m_key   [SLOTS];
  logic [VALUE_BITS-1:0] m_val   [SLOTS];
  int                    m_home  [SLOTS];
  int                    m_older [SLOTS];
  int                    m_newer [SLOTS];
  int                    m_front, m_count, m_tombs;
  logic [CNT_BITS-1:0]   m_max;

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   idle_cycles = 0;

  // Keys come from a small pool so finds hit and probes collide.
  logic [KEY_BITS-1:0] key_pool[64];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic int cap_limit();
    int m;
    m = m_max;
    if (m < 2) m = 2;
    if (m > SLOTS / 2) m = SLOTS / 2;
    return m;
  endfunction

  function automatic void link_front(int s);
    int f, t;
    if (m_count == 0) begin
      m_older[s] = s;
      m_newer[s] = s;
    end else begin
      f = m_front;
      t = m_newer[f];
      m_newer[s] = t;
      m_older[s] = f;
      m_older[t] = s;
      m_newer[f] = s;
    end
    m_front = s;
  endfunction

  function automatic void unlink(int s);
    int p, n;
    p = m_newer[s];
    n = m_older[s];
    m_older[p] = n;
    m_newer[n] = p;
  endfunction

  function automatic void move_to_front(int s);
    if (s == m_front) return;
    unlink(s);
    m_count--;
    link_front(s);
    m_count++;
  endfunction

  // Re-place live entries in recency order and drop all tombstones.
  function automatic void rebuild_table();
    logic [KEY_BITS-1:0]   tk[$];
    logic [VALUE_BITS-1:0] tv[$];
    int                    th[$];
    int                    s, d, prev;
    s = m_front;
    prev = 0;
    for (int i = 0; i < m_count; i++) begin
      tk.push_back(m_key[s]);
      tv.push_back(m_val[s]);
      th.push_back(m_home[s]);
      s = m_older[s];
    end
    foreach (m_tag[i]) m_tag[i] = TAG_EMPTY;
    m_tombs = 0;
    for (int i = 0; i < tk.size(); i++) begin
      for (int j = 0; j < SLOTS; j++) begin
        d = (th[i] + j) % SLOTS;
        if (m_tag[d] == TAG_EMPTY) begin
          m_tag[d] = TAG_LIVE;
          m_key[d] = tk[i];
          m_val[d] = tv[i];
          m_home[d] = th[i];
          if (i == 0) m_front = d;
          else begin
            m_older[prev] = d;
            m_newer[d] = prev;
          end
          prev = d;
          break;
        end
      end
    end
    if (tk.size() > 0) begin
      m_older[prev] = m_front;
      m_newer[m_front] = prev;
    end
  endfunction

  function automatic void evict_lru();
    int t;
    t = m_newer[m_front];
    unlink(t);
    m_tag[t] = TAG_TOMB;
    m_count--;
    m_tombs++;
    if (m_tombs * 3 > SLOTS) rebuild_table();
  endfunction

  function automatic void clear_cache();
    foreach (m_tag[i]) m_tag[i] = TAG_EMPTY;
    m_front = 0;
    m_count = 0;
    m_tombs = 0;
  endfunction

  function automatic rsp_t cache_lookup(req_t r);
    rsp_t o;
    int   s, j, tomb, d;
    bit   have_tomb, placed;
    o = '0;
    if (r.opcode == OP_FIND) begin
      for (j = 0; j < SLOTS; j++) begin
        s = (r.hash_index + j) % SLOTS;
        if (m_tag[s] == TAG_EMPTY) break;
        if (m_tag[s] == TAG_LIVE && m_key[s] == r.key) begin
          move_to_front(s);
          o.hit = 1'b1;
          o.found_value = m_val[s];
          break;
        end
      end
    end else if (r.opcode == OP_INSERT) begin
      have_tomb = 0;
      placed = 0;
      tomb = 0;
      while (m_count >= cap_limit() && m_count > 0) begin
        evict_lru();
        o.evicted = 1'b1;
      end
      for (j = 0; j < SLOTS; j++) begin
        s = (r.hash_index + j) % SLOTS;
        if (m_tag[s] == TAG_EMPTY) break;
        if (m_tag[s] == TAG_TOMB) begin
          if (!have_tomb) begin
            have_tomb = 1;
            tomb = s;
          end
        end else if (m_key[s] == r.key) begin
          m_val[s] = r.value;
          move_to_front(s);
          o.hit = 1'b1;
          placed = 1;
          break;
        end
      end
      if (!placed && (have_tomb || j < SLOTS)) begin
        if (have_tomb) begin
          d = tomb;
          m_tombs--;
        end else d = (r.hash_index + j) % SLOTS;
        m_tag[d] = TAG_LIVE;
        m_key[d] = r.key;
        m_val[d] = r.value;
        m_home[d] = r.hash_index;
        link_front(d);
        m_count++;
      end
    end else if (r.opcode == OP_CLEAR) clear_cache();
    return o;
  endfunction

  // Check each result strobe against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        want = pending_rsp.pop_front();
        if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
        if (rsp.found_value !== want.found_value)
          report_mismatch("found_value", rsp.found_value, want.found_value);
        if (rsp.evicted !== want.evicted)
          report_mismatch("evicted", rsp.evicted, want.evicted);
      end
    end
  end

  // Watchdog: count cycles with no request or result accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one request at the falling edge; hold it until the front queue takes it.
  // With no gap, start stays high and the next request follows directly.
  task automatic send_request(input req_t r, input bit has_want, input rsp_t want);
    rsp_t pred;
    int   w;
    w = $urandom_range(0, 14);
    if (w > 0) begin
      start <= 1'b0;
      repeat (w) @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pred = cache_lookup(r);
    if (has_want && pred !== want)
      $display("[%0t] directed row disagrees with prediction", $time);
    pending_rsp.push_back(has_want ? want : pred);
    @(negedge clk);
  endtask

  // Drop start, wait for all results, then let any trailing work drain.
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (2200) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_BITS-1:0] v);
    drain_pipe();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_max = v;
  endtask

  function automatic req_t mk(logic [1:0] op, logic [31:0] k, int h, logic [31:0] v);
    req_t r;
    r.opcode = op;
    r.key = k;
    r.hash_index = h[SLOT_BITS-1:0];
    r.value = v;
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit   has_want;
    rsp_t want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(req_t r, bit hw, bit h, logic [31:0] fv, bit ev);
    row_t x;
    x.r = r;
    x.has_want = hw;
    x.want.hit = h;
    x.want.found_value = fv;
    x.want.evicted = ev;
    rows.push_back(x);
  endfunction

  task automatic random_phase(input int n, input int hspan);
    req_t r;
    int   p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      r = '0;
      r.key = key_pool[$urandom_range(0, 63)];
      if ($urandom_range(0, 9) == 0) r.key = $urandom;
      r.hash_index = SLOT_BITS'((r.key[10:0] ^ r.key[31:21]) % hspan);
      if ($urandom_range(0, 19) == 0) r.hash_index = SLOT_BITS'($urandom);
      r.value = $urandom;
      if (p < 45) r.opcode = OP_FIND;
      else if (p < 98) r.opcode = OP_INSERT;
      else if (p < 99) r.opcode = OP_CLEAR;
      else r.opcode = OP_UNUSED;
      send_request(r, 0, '0);
    end
  endtask

  initial begin
    clear_cache();
    m_max = CNT_BITS'(1024);
    foreach (key_pool[i]) key_pool[i] = (i < 2) ? i : $urandom;
    key_pool[2] = 32'hFFFF_FFFF;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty cache, extreme keys and slots, keys 0 and 1, opcode 3.
    add_row(mk(OP_FIND, 32'h5, 0, 0), 1, 0, 0, 0);
    add_row(mk(OP_INSERT, 32'hFFFF_FFFF, 2047, 32'hFFFF_FFFF), 1, 0, 0, 0);
    add_row(mk(OP_FIND, 32'hFFFF_FFFF, 2047, 0), 1, 1, 32'hFFFF_FFFF, 0);
    add_row(mk(OP_INSERT, 32'h0, 2047, 32'h1), 0, 0, 0, 0);
    add_row(mk(OP_INSERT, 32'h1, 2047, 32'h2), 0, 0, 0, 0);
    add_row(mk(OP_FIND, 32'h0, 2047, 0), 0, 0, 0, 0);
    add_row(mk(OP_FIND, 32'h1, 2046, 0), 1, 0, 0, 0);
    add_row(mk(OP_INSERT, 32'h1, 2047, 32'h33), 0, 0, 0, 0);
    add_row(mk(OP_FIND, 32'h1, 2047, 0), 0, 0, 0, 0);
    add_row(mk(OP_UNUSED, 32'hFFFF_FFFF, 2047, 32'hFFFF_FFFF), 1, 0, 0, 0);
    add_row(mk(OP_CLEAR, 0, 0, 0), 1, 0, 0, 0);
    add_row(mk(OP_FIND, 32'hFFFF_FFFF, 2047, 0), 1, 0, 0, 0);
    add_row(mk(OP_INSERT, 32'h2, 0, 32'h1), 0, 0, 0, 0);
    foreach (rows[i]) send_request(rows[i].r, rows[i].has_want, rows[i].want);

    // Minimum capacity of 2: once full, each insert evicts, the reinserted key too.
    write_limit(CNT_BITS'(0));
    send_request(mk(OP_INSERT, 32'h10, 5, 32'h10), 0, '0);
    send_request(mk(OP_INSERT, 32'h11, 5, 32'h11), 0, '0);
    send_request(mk(OP_INSERT, 32'h10, 5, 32'h12), 0, '0);
    send_request(mk(OP_FIND, 32'h11, 5, 0), 0, '0);
    random_phase(200, 8);

    // Small capacity with heavy collisions; tombstones pile up.
    write_limit(CNT_BITS'(5));
    random_phase(350, 16);

    // Over the cap: saturates to half the table; lower below the count after.
    write_limit(CNT_BITS'(2047));
    random_phase(300, 2048);
    write_limit(CNT_BITS'(3));
    random_phase(250, 64);

    // Hold off until everything has drained, then continue with randomly spaced requests.
    write_limit(CNT_BITS'(1024));
    random_phase(400, 256);

    drain_pipe();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// File: lru_hash_cache.f
design/lhc_pkg.sv
design/lhc_front.sv
design/lhc_back.sv
design/lru_hash_cache.sv
design/lhc_checker.sv
dv/tb_lru_hash_cache.sv
